// ----- rtl/ecal_pkg.sv -----
// Shared types, widths and calendar tables for the epoch-to-calendar pipeline.
// No dependencies; every rtl module imports this package.
package ecal_pkg;

   localparam int TS_W     = 38;   // input timestamp width
   localparam int OFF_W    = 17;   // signed zone offset width
   localparam int DAYS_W   = 22;   // day count plus one, biased to stay positive
   localparam int SOD_W    = 17;   // second of day, 0..86399
   localparam int YEAR_W   = 14;
   localparam int DOY_W    = 9;

   localparam int TOD_STAGES   = 4;
   localparam int CIVIL_STAGES = 12;

   localparam int unsigned SECONDS_PER_DAY = 86400;
   localparam logic signed [OFF_W-1:0] ZONE_RESET = 17'sd28800;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } tod_type;

   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic [3:0]        month;
      logic [4:0]        day;
      logic [2:0]        weekday;
      logic [DOY_W-1:0]  year_day;
      logic              leap;
   } date_type;

   // Days from March 1st to the first of each March-based month.
   function automatic logic [DOY_W-1:0] mar_start(input logic [3:0] mp);
      logic [DOY_W-1:0] r;
      case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // Days before the first of each month in a common year; m is 1..12.
   function automatic logic [DOY_W-1:0] month_start(input logic [3:0] m);
      logic [DOY_W-1:0] r;
      case (m)
         4'd1:    r = 9'd0;
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/ecal_daysplit.sv -----
// Three-stage front end: apply zone offset, split local seconds into days and second of day.
// Depends on ecal_pkg.
module ecal_daysplit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_valid,
   input  logic [ecal_pkg::TS_W-1:0]          in_timestamp,
   input  logic signed [ecal_pkg::OFF_W-1:0]  in_zone,
   output logic                               out_valid,
   output logic [ecal_pkg::DAYS_W-1:0]        out_days1,
   output logic [ecal_pkg::SOD_W-1:0]         out_sod
);
   import ecal_pkg::*;

   localparam int LOC_W = TS_W + 1;
   localparam logic [LOC_W-1:0] DAY_BIAS = LOC_W'(SECONDS_PER_DAY);
   // floor(2^32 / 675): quotient estimate is exact or one low
   localparam logic [22:0] RECIP_675 = 23'd6362914;

   logic [2:0]        v_ff, v_in;
   logic [LOC_W-1:0]  loc_in, loc_ff;
   logic [54:0]       qprod;
   logic [DAYS_W-1:0] qest_in, qest_ff;
   logic [31:0]       quot_ff;
   logic [6:0]        lo_ff;
   logic [31:0]       rem32;
   logic [10:0]       rem;
   logic              fix;
   logic [DAYS_W-1:0] days1_in, days1_ff;
   logic [SOD_W-1:0]  sod_in, sod_ff;

   // biased by one day so the sum never goes negative
   assign loc_in = {1'b0, in_timestamp}
                 + {{(LOC_W-OFF_W){in_zone[OFF_W-1]}}, in_zone} + DAY_BIAS;

   assign qprod   = 55'(loc_ff[LOC_W-1:7]) * 55'(RECIP_675);
   assign qest_in = qprod[53:32];

   assign rem32    = quot_ff - 32'(qest_ff) * 32'd675;
   assign rem      = rem32[10:0];
   assign fix      = (rem >= 11'd675);
   assign days1_in = qest_ff + DAYS_W'(fix);
   assign sod_in   = {(fix ? 10'(rem - 11'd675) : rem[9:0]), lo_ff};

   assign v_in = {v_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         loc_ff   <= loc_in;
         qest_ff  <= qest_in;
         quot_ff  <= loc_ff[LOC_W-1:7];
         lo_ff    <= loc_ff[6:0];
         days1_ff <= days1_in;
         sod_ff   <= sod_in;
      end
   end

   assign out_valid = v_ff[2];
   assign out_days1 = days1_ff;
   assign out_sod   = sod_ff;

endmodule

// ----- rtl/ecal_tod.sv -----
// Time-of-day branch: hour, minute and second from second of day, aligned to the date branch.
// Depends on ecal_pkg.
module ecal_tod (
   input  logic                      clock,
   input  logic                      adv,
   input  logic [ecal_pkg::SOD_W-1:0] in_sod,
   output ecal_pkg::tod_type         out_tod
);
   import ecal_pkg::*;

   localparam int ALIGN = CIVIL_STAGES - TOD_STAGES;

   logic [34:0]      hprod;
   logic [4:0]       hour_in, hour1_ff, hour2_ff, hour3_ff;
   logic [SOD_W-1:0] sod1_ff;
   logic [16:0]      rs_full;
   logic [11:0]      rs_in, rs2_ff, rs3_ff;
   logic [24:0]      mprod;
   logic [5:0]       min_in, min3_ff;
   logic [11:0]      sec_full;
   tod_type          res_in, res_ff;
   tod_type          align_ff [ALIGN];

   // exact reciprocals for the value ranges here
   assign hprod   = 35'(in_sod) * 35'd149131;
   assign hour_in = hprod[33:29];

   assign rs_full = sod1_ff - 17'(hour1_ff) * 17'd3600;
   assign rs_in   = rs_full[11:0];

   assign mprod  = 25'(rs2_ff) * 25'd4370;
   assign min_in = mprod[23:18];

   assign sec_full      = rs3_ff - 12'(min3_ff) * 12'd60;
   assign res_in.hour   = hour3_ff;
   assign res_in.minute = min3_ff;
   assign res_in.second = sec_full[5:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         hour1_ff    <= hour_in;
         sod1_ff     <= in_sod;
         hour2_ff    <= hour1_ff;
         rs2_ff      <= rs_in;
         hour3_ff    <= hour2_ff;
         rs3_ff      <= rs2_ff;
         min3_ff     <= min_in;
         res_ff      <= res_in;
         align_ff[0] <= res_ff;
         for (int i = 1; i < ALIGN; i++) begin
            align_ff[i] <= align_ff[i-1];
         end
      end
   end

   assign out_tod = align_ff[ALIGN-1];

endmodule

// ----- rtl/ecal_civil.sv -----
// Twelve-stage date branch: era split, year of era, month and day, weekday, day of year.
// Depends on ecal_pkg.
module ecal_civil (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic [ecal_pkg::DAYS_W-1:0] in_days1,
   output logic                       out_valid,
   output ecal_pkg::date_type         out_date
);
   import ecal_pkg::*;

   localparam logic [17:0] ERA_DAYS = 18'd146097;

   logic [CIVIL_STAGES-1:0] v_ff, v_in;

   // stage 1
   logic [DAYS_W-1:0] z_in, z1_ff, z2_ff, wx_in, wx1_ff, wx2_ff;
   // stage 2
   logic [36:0] eprod;
   logic [44:0] wprod;
   logic [4:0]  era_e_in, era_e_ff;
   logic [19:0] wq_in, wq_ff;
   // stage 3
   logic [DAYS_W-1:0] dd_full, wd_full;
   logic [18:0] dd;
   logic        efix;
   logic [4:0]  era_in;
   logic [17:0] doe_in;
   logic [2:0]  wday_in;
   logic [4:0]  era_ff  [8];
   logic [17:0] doe_ff  [5];
   logic [2:0]  wday_ff [9];
   // stage 4
   logic [35:0] aprod;
   logic [6:0]  a_in, a_ff;
   logic [2:0]  b_in, b_ff;
   logic        c_in, c_ff;
   // stage 5
   logic [17:0] n_in, n_ff;
   // stage 6
   logic [36:0] yprod;
   logic [8:0]  yoe_in;
   logic [8:0]  yoe_ff [5];
   // stage 7
   logic [18:0] cprod;
   logic [1:0]  y100_in, y100_ff;
   logic [17:0] t_in, t_ff;
   // stage 8
   logic [17:0] doy_full;
   logic [8:0]  doy_in;
   logic [8:0]  doy_ff [3];
   // stage 9
   logic [10:0] x5_in, x5_ff;
   // stage 10
   logic [23:0] mpprod;
   logic [3:0]  mp_in, mp_ff;
   // stage 11
   logic [8:0]        d_full, yadj, ymod;
   logic [4:0]        d_in, d_ff;
   logic [3:0]        m_in, m_ff;
   logic [YEAR_W-1:0] year_in, year_ff;
   logic              leap_in, leap_ff;
   // stage 12
   date_type          date_in, date_ff;

   // stage 1: shift to the March-based civil day count and the weekday count
   assign z_in  = in_days1 + 22'd719467;
   assign wx_in = in_days1 + 22'd719526;

   // stage 2: era estimate (exact or one low), weekday quotient (exact)
   assign eprod    = 37'(z1_ff) * 37'd29398;
   assign era_e_in = eprod[36:32];
   assign wprod    = 45'(wx1_ff) * 45'd4793491;
   assign wq_in    = wprod[44:25];

   // stage 3: correct the era, day of era, weekday 1..7
   assign dd_full = z2_ff - 22'(era_e_ff) * 22'(ERA_DAYS);
   assign dd      = dd_full[18:0];
   assign efix    = (dd >= 19'(ERA_DAYS));
   assign era_in  = era_e_ff + 5'(efix);
   assign doe_in  = efix ? 18'(dd - 19'(ERA_DAYS)) : dd[17:0];
   assign wd_full = wx2_ff - 22'(wq_ff) * 22'd7;
   assign wday_in = wd_full[2:0] + 3'd1;

   // stage 4: terms of the year-of-era formula
   assign aprod = 36'(doe_ff[0]) * 36'd183860;
   assign a_in  = aprod[34:28];
   assign b_in  = 3'(doe_ff[0] >= 18'd36524) + 3'(doe_ff[0] >= 18'd73048)
                + 3'(doe_ff[0] >= 18'd109572) + 3'(doe_ff[0] >= 18'd146096);
   assign c_in  = (doe_ff[0] == 18'd146096);

   // stage 5
   assign n_in = doe_ff[1] - 18'(a_ff) + 18'(b_ff) - 18'(c_ff);

   // stage 6: divide by 365
   assign yprod  = 37'(n_ff) * 37'd367720;
   assign yoe_in = yprod[35:27];

   // stage 7: days before this year of era
   assign cprod   = 19'(yoe_ff[0]) * 19'd656;
   assign y100_in = cprod[17:16];
   assign t_in    = 18'(yoe_ff[0]) * 18'd365 + 18'(yoe_ff[0][8:2]);

   // stage 8: day of March-based year
   assign doy_full = doe_ff[4] - (t_ff - 18'(y100_ff));
   assign doy_in   = doy_full[8:0];

   // stage 9
   assign x5_in = 11'(doy_ff[0]) * 11'd5 + 11'd2;

   // stage 10: divide by 153
   assign mpprod = 24'(x5_ff) * 24'd6854;
   assign mp_in  = mpprod[23:20];

   // stage 11: month, day, year and leap flag
   assign d_full  = doy_ff[2] - mar_start(mp_ff) + 9'd1;
   assign d_in    = d_full[4:0];
   assign m_in    = (mp_ff < 4'd10) ? mp_ff + 4'd3 : mp_ff - 4'd9;
   assign yadj    = yoe_ff[4] + 9'(mp_ff >= 4'd10);
   assign year_in = 14'(era_ff[7]) * 14'd400 + 14'(yadj);
   // year mod 400 decides the leap rule
   assign ymod    = (yadj == 9'd400) ? 9'd0 : yadj;
   assign leap_in = (ymod[1:0] == 2'd0) && (ymod != 9'd100)
                 && (ymod != 9'd200) && (ymod != 9'd300);

   // stage 12: day of calendar year, with the whole date registered
   assign date_in.year     = year_ff;
   assign date_in.month    = m_ff;
   assign date_in.day      = d_ff;
   assign date_in.weekday  = wday_ff[8];
   assign date_in.leap     = leap_ff;
   assign date_in.year_day = month_start(m_ff) + 9'(d_ff) - 9'd1
                           + 9'(leap_ff && (m_ff > 4'd2));

   assign v_in = {v_ff[CIVIL_STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         z1_ff    <= z_in;
         wx1_ff   <= wx_in;
         z2_ff    <= z1_ff;
         wx2_ff   <= wx1_ff;
         era_e_ff <= era_e_in;
         wq_ff    <= wq_in;
         era_ff[0]  <= era_in;
         doe_ff[0]  <= doe_in;
         wday_ff[0] <= wday_in;
         for (int i = 1; i < 8; i++) begin
            era_ff[i] <= era_ff[i-1];
         end
         for (int i = 1; i < 5; i++) begin
            doe_ff[i] <= doe_ff[i-1];
         end
         for (int i = 1; i < 9; i++) begin
            wday_ff[i] <= wday_ff[i-1];
         end
         a_ff      <= a_in;
         b_ff      <= b_in;
         c_ff      <= c_in;
         n_ff      <= n_in;
         yoe_ff[0] <= yoe_in;
         for (int i = 1; i < 5; i++) begin
            yoe_ff[i] <= yoe_ff[i-1];
         end
         y100_ff   <= y100_in;
         t_ff      <= t_in;
         doy_ff[0] <= doy_in;
         for (int i = 1; i < 3; i++) begin
            doy_ff[i] <= doy_ff[i-1];
         end
         x5_ff   <= x5_in;
         mp_ff   <= mp_in;
         d_ff    <= d_in;
         m_ff    <= m_in;
         year_ff <= year_in;
         leap_ff <= leap_in;
         date_ff <= date_in;
      end
   end

   assign out_valid = v_ff[CIVIL_STAGES-1];
   assign out_date  = date_ff;

endmodule

// ----- rtl/epoch_seconds_to_calendar_core.sv -----
// Top level of the epoch-seconds to local calendar converter.
// Depends on ecal_pkg, ecal_daysplit, ecal_tod and ecal_civil.
//
// Converts a count of seconds since 1970-01-01 00:00:00 UTC, shifted by a
// signed zone offset, into the local proleptic Gregorian date and time of
// day, plus weekday (1 Sunday .. 7 Saturday), zero-based day of year and a
// leap-year flag. The block is a fully pipelined datapath: it takes one beat
// per cycle unless the result side stalls, and returns results in order, one
// result per request. Three stages split local seconds into days and second
// of day by reciprocal multiplication, then twelve stages run the date
// conversion (era, year of era, month, day) while the time-of-day branch is
// held in line with it. A stall on the result side freezes the whole
// pipeline, so req_stall follows rsp_stall whenever a result is waiting;
// bubbles travel through as cleared valid bits. The zone offset register
// resets to 28800 (UTC+8) and is written through the csr channel, which is
// always ready; write it only while no request is in flight.
module epoch_seconds_to_calendar_core (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ecal_pkg::TS_W-1:0]         req_timestamp,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ecal_pkg::YEAR_W-1:0]       rsp_year,
   output logic [3:0]                        rsp_month,
   output logic [4:0]                        rsp_day,
   output logic [4:0]                        rsp_hour,
   output logic [5:0]                        rsp_minute,
   output logic [5:0]                        rsp_second,
   output logic [2:0]                        rsp_weekday,
   output logic [ecal_pkg::DOY_W-1:0]        rsp_year_day,
   output logic                              rsp_leap,
   // zone offset write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic signed [ecal_pkg::OFF_W-1:0] csr_zone_offset_seconds
);
   import ecal_pkg::*;

   logic                     adv;
   logic signed [OFF_W-1:0]  zone_ff, zone_in;
   logic                     split_valid;
   logic [DAYS_W-1:0]        split_days1;
   logic [SOD_W-1:0]         split_sod;
   tod_type                  tod;
   date_type                 date;

   // advance every stage unless a finished result is held back
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   assign zone_in = csr_valid ? csr_zone_offset_seconds : zone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= ZONE_RESET;
      end else begin
         zone_ff <= zone_in;
      end
   end

   // local seconds -> day count (plus one) and second of day
   ecal_daysplit u_daysplit (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (req_valid),
      .in_timestamp (req_timestamp),
      .in_zone      (zone_ff),
      .out_valid    (split_valid),
      .out_days1    (split_days1),
      .out_sod      (split_sod)
   );

   // hour, minute, second; delayed to match the date branch
   ecal_tod u_tod (
      .clock   (clock),
      .adv     (adv),
      .in_sod  (split_sod),
      .out_tod (tod)
   );

   // date fields and weekday; owns the result valid bit
   ecal_civil u_civil (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (split_valid),
      .in_days1  (split_days1),
      .out_valid (rsp_valid),
      .out_date  (date)
   );

   assign rsp_year     = date.year;
   assign rsp_month    = date.month;
   assign rsp_day      = date.day;
   assign rsp_weekday  = date.weekday;
   assign rsp_year_day = date.year_day;
   assign rsp_leap     = date.leap;
   assign rsp_hour     = tod.hour;
   assign rsp_minute   = tod.minute;
   assign rsp_second   = tod.second;

endmodule

// ----- sim/calendar_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the epoch-to-calendar core: predicts each result from the request beat
// and the zone offset it has seen written, then compares in order. Depends on ecal_pkg.
module calendar_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [ecal_pkg::TS_W-1:0]          req_timestamp,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [ecal_pkg::YEAR_W-1:0]        rsp_year,
   input  logic [3:0]                         rsp_month,
   input  logic [4:0]                         rsp_day,
   input  logic [4:0]                         rsp_hour,
   input  logic [5:0]                         rsp_minute,
   input  logic [5:0]                         rsp_second,
   input  logic [2:0]                         rsp_weekday,
   input  logic [ecal_pkg::DOY_W-1:0]         rsp_year_day,
   input  logic                               rsp_leap,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic signed [ecal_pkg::OFF_W-1:0]  csr_zone_offset_seconds,
   output int                                 outstanding,
   output int                                 failures
);
   import ecal_pkg::*;

   typedef struct {
      logic [TS_W-1:0] stamp;
      date_type        date;
      tod_type         tod;
   } calendar_beat_type;

   localparam int MAX_PRINTED = 100;

   // days before the first of each month in a common year
   localparam int DAYS_BEFORE_MONTH [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                             304, 334};

   calendar_beat_type        calendar_q [$];
   logic signed [OFF_W-1:0]  zone_offset;
   int                       mismatch_count = 0;

   function automatic calendar_beat_type local_calendar(input logic [TS_W-1:0] stamp,
                                                        input logic signed [OFF_W-1:0] zone);
      longint            total, sod, days, z, doe, yoe, yr, doy_mar, mp, dd, mm, yday;
      bit                lp;
      calendar_beat_type r;
      total = longint'(stamp) + longint'(zone);
      sod = total % 86400;
      if (sod < 0) sod += 86400;
      days = (total - sod) / 86400;
      // March-based civil date from the day count, 400-year eras
      z       = days + 719468;
      yr      = (z / 146097) * 400;
      doe     = z % 146097;
      yoe     = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      yr      = yr + yoe;
      doy_mar = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp      = (5 * doy_mar + 2) / 153;
      dd      = doy_mar - (153 * mp + 2) / 5 + 1;
      mm      = (mp < 10) ? mp + 3 : mp - 9;
      if (mm <= 2) yr = yr + 1;
      lp   = (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
      yday = DAYS_BEFORE_MONTH[mm - 1] + dd - 1;
      if (lp && mm > 2) yday = yday + 1;
      r.stamp         = stamp;
      r.date.year     = yr[YEAR_W-1:0];
      r.date.month    = mm[3:0];
      r.date.day      = dd[4:0];
      r.date.weekday  = 3'(((days + 719527) % 7) + 1);
      r.date.year_day = yday[DOY_W-1:0];
      r.date.leap     = lp;
      r.tod.hour      = 5'(sod / 3600);
      r.tod.minute    = 6'((sod / 60) % 60);
      r.tod.second    = 6'(sod % 60);
      return r;
   endfunction

   task automatic note_mismatch(input string what);
      if (mismatch_count < MAX_PRINTED) $display("mismatch: %s", what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want,
                              input logic [TS_W-1:0] stamp);
      if (got !== want)
         note_mismatch($sformatf("%s got %0d want %0d (timestamp %0d, zone %0d)",
                                 name, got, want, stamp, zone_offset));
   endtask

   always @(posedge clock) begin : watch
      calendar_beat_type want;
      if (reset) begin
         zone_offset = ZONE_RESET;
      end else begin
         // retire the oldest prediction against each result beat
         if (rsp_valid && !rsp_stall) begin
            if (calendar_q.size() == 0) begin
               note_mismatch($sformatf("result beat with nothing pending, year %0d", rsp_year));
            end else begin
               want = calendar_q.pop_front();
               check_field("year", 16'(rsp_year), 16'(want.date.year), want.stamp);
               check_field("month", 16'(rsp_month), 16'(want.date.month), want.stamp);
               check_field("day", 16'(rsp_day), 16'(want.date.day), want.stamp);
               check_field("hour", 16'(rsp_hour), 16'(want.tod.hour), want.stamp);
               check_field("minute", 16'(rsp_minute), 16'(want.tod.minute), want.stamp);
               check_field("second", 16'(rsp_second), 16'(want.tod.second), want.stamp);
               check_field("weekday", 16'(rsp_weekday), 16'(want.date.weekday), want.stamp);
               check_field("year_day", 16'(rsp_year_day), 16'(want.date.year_day),
                           want.stamp);
               check_field("leap", 16'(rsp_leap), 16'(want.date.leap), want.stamp);
            end
         end
         if (req_valid && !req_stall)
            calendar_q.push_back(local_calendar(req_timestamp, zone_offset));
         if (csr_valid && csr_ready) zone_offset = csr_zone_offset_seconds;
      end
      outstanding <= calendar_q.size();
      failures    <= mismatch_count;
   end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Top of the epoch-to-calendar simulation: clock, reset, stimulus and verdict.
// Depends on ecal_pkg, epoch_seconds_to_calendar_core and calendar_checker.
module testbench;
   import ecal_pkg::*;

   // depth of the core's pipeline, from request beat to result beat
   localparam int PIPE_LATENCY   = 15;
   localparam int HOLD_OFF_BEATS = 400;
   localparam logic [TS_W-1:0] TS_MAX    = {TS_W{1'b1}};
   localparam logic [TS_W-1:0] YEAR_9999 = 38'd253402300799;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [TS_W-1:0]          req_timestamp;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [YEAR_W-1:0]        rsp_year;
   logic [3:0]               rsp_month;
   logic [4:0]               rsp_day;
   logic [4:0]               rsp_hour;
   logic [5:0]               rsp_minute;
   logic [5:0]               rsp_second;
   logic [2:0]               rsp_weekday;
   logic [DOY_W-1:0]         rsp_year_day;
   logic                     rsp_leap;
   logic                     csr_valid;
   logic                     csr_ready;
   logic signed [OFF_W-1:0]  csr_zone_offset_seconds;

   int                       outstanding;
   int                       failures;

   // zone offset the core holds now, used to aim stimulus at local day boundaries
   logic signed [OFF_W-1:0]  zone_now = ZONE_RESET;
   // request side runs this many beats back to back before random gaps resume
   int                       calm_left = 0;
   // the stall process serves one long hold-off per request
   int                       hold_off_requests = 0;
   int                       hold_off_served = 0;

   always #5 clock = ~clock;

   epoch_seconds_to_calendar_core i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_timestamp           (req_timestamp),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_year                (rsp_year),
      .rsp_month               (rsp_month),
      .rsp_day                 (rsp_day),
      .rsp_hour                (rsp_hour),
      .rsp_minute              (rsp_minute),
      .rsp_second              (rsp_second),
      .rsp_weekday             (rsp_weekday),
      .rsp_year_day            (rsp_year_day),
      .rsp_leap                (rsp_leap),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_zone_offset_seconds (csr_zone_offset_seconds)
   );

   calendar_checker u_calendar_checker (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_timestamp           (req_timestamp),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_year                (rsp_year),
      .rsp_month               (rsp_month),
      .rsp_day                 (rsp_day),
      .rsp_hour                (rsp_hour),
      .rsp_minute              (rsp_minute),
      .rsp_second              (rsp_second),
      .rsp_weekday             (rsp_weekday),
      .rsp_year_day            (rsp_year_day),
      .rsp_leap                (rsp_leap),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_zone_offset_seconds (csr_zone_offset_seconds),
      .outstanding             (outstanding),
      .failures                (failures)
   );

   // Idle length before a request beat: mostly none or short, a few long, and now and
   // then a calm stretch of back-to-back beats.
   function automatic int request_gap();
      int unsigned r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(30, 80);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Pick a timestamp: uniform over the documented range, over all 38 bits, near the
   // epoch (dates in 1969 under negative zones), just around a local midnight, or at
   // the very top of the field.
   function automatic logic [TS_W-1:0] random_timestamp(input logic signed [OFF_W-1:0] zone);
      int unsigned pick;
      longint      stamp;
      logic [63:0] wide;
      pick = $urandom_range(0, 99);
      wide = {$urandom, $urandom};
      if (pick < 30) begin
         stamp = longint'(wide % 64'd253402300800);
      end else if (pick < 45) begin
         stamp = longint'(wide[TS_W-1:0]);
      end else if (pick < 60) begin
         stamp = longint'($urandom_range(0, 200000));
      end else if (pick < 92) begin
         stamp = longint'($urandom_range(0, 2932896)) * 86400 - longint'(zone)
                 + longint'($urandom_range(0, 6)) - 3;
         if (stamp < 0) stamp = 0;
      end else begin
         stamp = longint'(TS_MAX) - longint'($urandom_range(0, 100000));
      end
      return stamp[TS_W-1:0];
   endfunction

   // Offer one request beat and hold it until the core takes it. Call at a rising edge;
   // returns at the edge that accepted the beat, with valid still high.
   task automatic send_timestamp(input logic [TS_W-1:0] stamp);
      int gap;
      gap = request_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_timestamp <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_timestamp(random_timestamp(zone_now));
   endtask

   // Drop valid, drain every pending result, then let the pipeline run empty.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 5) @(posedge clock);
   endtask

   // Write the zone offset register; only called with the pipeline drained.
   task automatic write_zone(input logic signed [OFF_W-1:0] zone);
      csr_valid               <= 1'b1;
      csr_zone_offset_seconds <= zone;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      zone_now  = zone;
      @(posedge clock);
   endtask

   // Result side: random stall bursts, long free stretches, and a long hold-off on
   // request so the pipeline backs up and stalls the request side.
   initial begin : stall_driver
      int free_beats, busy_beats;
      int unsigned r;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_requests != hold_off_served) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_BEATS) @(posedge clock);
            hold_off_served++;
         end
         r = $urandom_range(0, 99);
         if (r < 70) free_beats = $urandom_range(1, 4);
         else if (r < 95) free_beats = $urandom_range(5, 30);
         else free_beats = $urandom_range(100, 300);
         r = $urandom_range(0, 99);
         if (r < 60) busy_beats = 0;
         else if (r < 90) busy_beats = $urandom_range(1, 3);
         else if (r < 98) busy_beats = $urandom_range(4, 12);
         else busy_beats = $urandom_range(30, 80);
         // free_beats is at least one, so stall never drops and rises in one step
         rsp_stall <= 1'b0;
         repeat (free_beats) @(posedge clock);
         if (busy_beats > 0) begin
            rsp_stall <= 1'b1;
            repeat (busy_beats) @(posedge clock);
         end
      end
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      reset                   <= 1'b1;
      req_valid               <= 1'b0;
      req_timestamp           <= '0;
      csr_valid               <= 1'b0;
      csr_zone_offset_seconds <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset zone (UTC+8): field extremes, local midnights, leap days in 1972 and 2000,
      // the missing one in 2100, the last second of 9999 and everything past it.
      send_timestamp(38'd0);
      send_timestamp(38'd1);
      send_timestamp(38'd57599);
      send_timestamp(38'd57600);
      send_timestamp(38'd68140799);
      send_timestamp(38'd68140800);
      send_timestamp(38'd951753600);
      send_timestamp(38'd951839999);
      send_timestamp(38'd978278399);
      send_timestamp(38'd4107513600);
      send_timestamp(38'd4107599999);
      send_timestamp(YEAR_9999);
      send_timestamp(YEAR_9999 + 38'd1);
      send_timestamp(38'h20_0000_0000);
      send_timestamp(TS_MAX);
      // back the pipeline up once while beats keep coming
      hold_off_requests <= hold_off_requests + 1;
      send_random(150);
      drain_pipeline();

      // Most negative documented zone: the epoch lands on the last day of 1969.
      write_zone(-17'sd50400);
      send_timestamp(38'd0);
      send_timestamp(38'd50399);
      send_timestamp(38'd50400);
      send_random(150);
      drain_pipeline();

      // Most negative register value.
      write_zone(-17'sd65536);
      send_timestamp(38'd0);
      send_timestamp(38'd65535);
      send_timestamp(38'd65536);
      send_timestamp(TS_MAX);
      send_random(120);
      drain_pipeline();

      // Most positive register value, top of the timestamp field.
      write_zone(17'sd65535);
      send_timestamp(38'd0);
      send_timestamp(TS_MAX - 38'd65535);
      send_timestamp(TS_MAX);
      send_random(120);
      drain_pipeline();

      write_zone(17'sd0);
      send_random(120);
      drain_pipeline();

      write_zone(17'sd50400);
      send_random(120);
      drain_pipeline();

      // Arbitrary register values.
      repeat (3) begin
         write_zone(OFF_W'($urandom_range(0, (1 << OFF_W) - 1)));
         send_random(80);
         drain_pipeline();
      end

      // drain_pipeline has already waited for every result and the pipeline depth
      repeat (PIPE_LATENCY) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
